[rtl/bb3_pkg.sv]
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants and types of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 24;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int CHAN_W      = 8;

    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CMP_W       = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              frame_end;
    } out_item_t;

    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic top_in;
        logic bot_in;
        logic left_a;
        logic left_b;
        logic frame_end;
    } emit_info_t;

endpackage

[rtl/bb3_ram.sv]
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bb3_fifo.sv]
// ----------------------------------------------------------------------------
// bb3_fifo
// Result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
module bb3_fifo import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_a,
    input  out_item_t             item_a,
    input  logic                  push_b,
    input  out_item_t             item_b,
    input  logic                  pop,
    output out_item_t             head,
    output logic [FIFO_CNT_W-1:0] count
);

    out_item_t             mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_b;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign wr_ptr_b = push_a ? wr_ptr_reg + 1'b1 : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
                      - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_ptr_reg] <= item_a;
        end
        if (push_b)
        begin
            mem[wr_ptr_b] <= item_b;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

[rtl/box_blur_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over an RGB pixel stream in raster order.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless in_stall is high; items pass
// registered read, window and sum stages into a 16-entry output queue. The
// item at the end of a row yields up to two output pixels. The queue drains
// one item per clock unless out_stall is high, and the input stalls only
// when the queue could not hold the results of the items still in the
// pipeline. Both line stores share one 2048 x 48 bit RAM with a registered
// read, read at the column of each used item and written back in the next
// cycle for pixel items. After the last pixel of a frame the host sends one
// row of flush items to end the last row; a register write restarts the frame.
module box_blur_3x3_rgb import bb3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [CHAN_W-1:0]      pixel_red,
    input  logic [CHAN_W-1:0]      pixel_green,
    input  logic [CHAN_W-1:0]      pixel_blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAN_W-1:0]      blur_red,
    output logic [CHAN_W-1:0]      blur_green,
    output logic [CHAN_W-1:0]      blur_blue,
    output logic                   row_end,
    output logic                   frame_end
);

    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        case (cnt)
            4'd1:    recip = 17'd65536;
            4'd2:    recip = 17'd32768;
            4'd3:    recip = 17'd21846;
            4'd4:    recip = 17'd16384;
            4'd5:    recip = 17'd13108;
            4'd6:    recip = 17'd10923;
            4'd7:    recip = 17'd9363;
            4'd8:    recip = 17'd8192;
            4'd9:    recip = 17'd7282;
            default: recip = '0;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] round_div(input logic [SUM_W-1:0] sum,
                                                    input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0]         num;
        logic [SUM_W+RECIP_W-1:0] prod;
        num  = sum + SUM_W'(cnt >> 1);
        prod = (SUM_W+RECIP_W)'(num) * (SUM_W+RECIP_W)'(recip(cnt));
        return prod[RECIP_SHIFT +: CHAN_W];
    endfunction

    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [ADDR_W-1:0]     col_reg;
    logic [ADDR_W-1:0]     col_next;
    logic [HEIGHT_W-1:0]   row_reg;
    logic [HEIGHT_W-1:0]   row_next;
    logic                  flushing_reg;
    logic                  flushing_next;

    logic [CMP_W-1:0]      w_eff;
    logic [CMP_W-1:0]      w_last;
    logic [HEIGHT_W-1:0]   h_eff;
    logic [ADDR_W-1:0]     cur_col;
    logic                  at_row_end;
    logic [HEIGHT_W:0]     row_inc;
    logic                  take;
    logic                  act;
    logic                  cfg_hit;
    emit_info_t            info_in;
    logic [PIX_W-1:0]      bottom_in;

    logic                  v1_reg;
    logic                  op1_reg;
    logic [PIX_W-1:0]      bottom1_reg;
    logic [ADDR_W-1:0]     col1_reg;
    emit_info_t            info1_reg;
    logic                  fwd1_reg;
    logic [LINE_W-1:0]     fwd_data_reg;
    logic [LINE_W-1:0]     ram_rdata;
    logic [LINE_W-1:0]     line_s1;
    logic [PIX_W-1:0]      top_s1;
    logic [PIX_W-1:0]      mid_s1;
    logic                  fwd_next;

    logic [PIX_W-1:0]      win_reg [3][3];
    logic                  v2_reg;
    emit_info_t            info2_reg;
    logic [SUM_W-1:0]      sum_a [3];
    logic [SUM_W-1:0]      sum_b [3];
    logic [CNT_W-1:0]      cnt_a;
    logic [CNT_W-1:0]      cnt_b;

    logic                  v3_reg;
    emit_info_t            info3_reg;
    logic [SUM_W-1:0]      sum_a_reg [3];
    logic [SUM_W-1:0]      sum_b_reg [3];
    logic [CNT_W-1:0]      cnt_a_reg;
    logic [CNT_W-1:0]      cnt_b_reg;

    out_item_t             item_a;
    out_item_t             item_b;
    out_item_t             head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [2:0]            inflight;
    logic [FIFO_CNT_W:0]   need;
    logic                  pop;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(width_reg);
        end
        w_last = w_eff - 1'b1;
        h_eff  = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign cur_col    = (CMP_W'(col_reg) > w_last) ? w_last[ADDR_W-1:0] : col_reg;
    assign at_row_end = (CMP_W'(cur_col) == w_last);
    assign row_inc    = (HEIGHT_W+1)'(row_reg) + 1'b1;
    assign take       = in_valid && !in_stall;
    assign act        = take && (op == flushing_reg);
    assign cfg_hit    = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
                                   || (cfg_index == REG_IMAGE_HEIGHT));
    assign bottom_in  = op ? '0 : {pixel_blue, pixel_green, pixel_red};

    always_comb
    begin
        info_in.emit_a    = (row_reg != '0) && (cur_col != '0);
        info_in.emit_b    = (row_reg != '0) && at_row_end;
        info_in.top_in    = (row_reg >= HEIGHT_W'(2));
        info_in.bot_in    = (row_reg < h_eff);
        info_in.left_a    = (cur_col >= ADDR_W'(2));
        info_in.left_b    = (cur_col != '0);
        info_in.frame_end = (row_reg == h_eff);
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        if (cfg_hit)
        begin
            col_next      = '0;
            row_next      = '0;
            flushing_next = 1'b0;
        end
        else if (act)
        begin
            if (at_row_end)
            begin
                col_next = '0;
                if (op)
                begin
                    row_next      = '0;
                    flushing_next = 1'b0;
                end
                else
                begin
                    row_next = row_inc[HEIGHT_W-1:0];
                    if (row_inc >= (HEIGHT_W+1)'(h_eff))
                    begin
                        flushing_next = 1'b1;
                    end
                end
            end
            else
            begin
                col_next = cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_IMAGE_WIDTH))
            begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT))
            begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            flushing_reg <= flushing_next;
        end
    end

    // The line RAM is written in the cycle after it is read, so a read of the
    // column being written in the same cycle takes the new line from a bypass.
    assign fwd_next = v1_reg && !op1_reg && (col1_reg == cur_col);
    assign line_s1  = fwd1_reg ? fwd_data_reg : ram_rdata;
    assign top_s1   = line_s1[LINE_W-1:PIX_W];
    assign mid_s1   = line_s1[PIX_W-1:0];

    bb3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (v1_reg && !op1_reg),
        .waddr (col1_reg),
        .wdata ({mid_s1, bottom1_reg}),
        .re    (act),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= act;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            op1_reg      <= op;
            bottom1_reg  <= bottom_in;
            col1_reg     <= cur_col;
            info1_reg    <= info_in;
            fwd1_reg     <= fwd_next;
            fwd_data_reg <= {mid_s1, bottom1_reg};
        end
        if (v1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_s1;
            win_reg[1][2] <= mid_s1;
            win_reg[2][2] <= bottom1_reg;
            info2_reg     <= info1_reg;
        end
        if (v2_reg)
        begin
            info3_reg <= info2_reg;
            cnt_a_reg <= cnt_a;
            cnt_b_reg <= cnt_b;
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_a_reg[ch] <= sum_a[ch];
                sum_b_reg[ch] <= sum_b[ch];
            end
        end
    end

    always_comb
    begin
        logic             row_ok;
        logic             use_a;
        logic             use_b;
        logic [SUM_W-1:0] px;
        logic [1:0]       rows;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_a[ch] = '0;
            sum_b[ch] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            row_ok = (i == 0) ? info2_reg.top_in : ((i == 2) ? info2_reg.bot_in : 1'b1);
            for (int j = 0; j < 3; j++)
            begin
                use_a = row_ok && ((j != 0) || info2_reg.left_a);
                use_b = row_ok && (j != 0) && ((j != 1) || info2_reg.left_b);
                for (int ch = 0; ch < 3; ch++)
                begin
                    px = SUM_W'(win_reg[i][j][CHAN_W*ch +: CHAN_W]);
                    if (use_a)
                    begin
                        sum_a[ch] = sum_a[ch] + px;
                    end
                    if (use_b)
                    begin
                        sum_b[ch] = sum_b[ch] + px;
                    end
                end
            end
        end
        rows  = 2'd1 + 2'(info2_reg.top_in) + 2'(info2_reg.bot_in);
        cnt_a = CNT_W'(rows) * (info2_reg.left_a ? CNT_W'(3) : CNT_W'(2));
        cnt_b = CNT_W'(rows) * (info2_reg.left_b ? CNT_W'(2) : CNT_W'(1));
    end

    always_comb
    begin
        item_a.red       = round_div(sum_a_reg[0], cnt_a_reg);
        item_a.green     = round_div(sum_a_reg[1], cnt_a_reg);
        item_a.blue      = round_div(sum_a_reg[2], cnt_a_reg);
        item_a.row_end   = 1'b0;
        item_a.frame_end = 1'b0;
        item_b.red       = round_div(sum_b_reg[0], cnt_b_reg);
        item_b.green     = round_div(sum_b_reg[1], cnt_b_reg);
        item_b.blue      = round_div(sum_b_reg[2], cnt_b_reg);
        item_b.row_end   = 1'b1;
        item_b.frame_end = info3_reg.frame_end;
    end

    bb3_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (v3_reg && info3_reg.emit_a),
        .item_a (item_a),
        .push_b (v3_reg && info3_reg.emit_b),
        .item_b (item_b),
        .pop    (pop),
        .head   (head),
        .count  (fifo_count)
    );

    assign inflight = 3'(v1_reg) + 3'(v2_reg) + 3'(v3_reg) + 3'd1;
    assign need     = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'({inflight, 1'b0});
    assign in_stall = (need > (FIFO_CNT_W+1)'(FIFO_DEPTH));

    assign out_valid  = (fifo_count != '0);
    assign pop        = out_valid && !out_stall;
    assign blur_red   = head.red;
    assign blur_green = head.green;
    assign blur_blue  = head.blue;
    assign row_end    = head.row_end;
    assign frame_end  = head.frame_end;

endmodule

[tb/box_blur_3x3_rgb_tb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb
// Self-checking testbench of the 3x3 RGB box blur.
//
// A short list of directed frames comes first. It covers tiny frames, extreme
// colors, ignored flush and pixel items, and width and height of zero and one.
// Random frames follow with random sizes and content. Some frames are cut
// short by a register write, and some carry stray items that the block must
// ignore. A behavioral model of line stores and window predicts each blurred
// pixel the plan does not fix; outputs are checked field by field in order.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;

    import bb3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int HOLD_CYCLES   = 400;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_FLUSH, ROW_WIDTH, ROW_HEIGHT} plan_kind_t;

    typedef struct packed {
        plan_kind_t  kind;
        logic [15:0] value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        int          nres;
        out_item_t   first;
        out_item_t   second;
    } plan_row_t;

    localparam out_item_t NO_OUT          = '0;
    localparam out_item_t WHITE           = '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0};
    localparam out_item_t WHITE_ROW_END   = '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0};
    localparam out_item_t WHITE_FRAME_END = '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1};
    localparam out_item_t LONE_PIXEL      = '{8'd18, 8'd200, 8'd7, 1'b1, 1'b1};

    // A negative result count means the row is checked against the model.
    localparam int PLAN_ROWS = 34;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_WIDTH,  16'd2, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_HEIGHT, 16'd2, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd9,   8'd9,   8'd9,    0, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd255, 8'd255,  0, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd255, 8'd255,  0, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd255, 8'd255,  0, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd255, 8'd255,  2, WHITE, WHITE_ROW_END},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,    0, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd0,   8'd0,   8'd0,    0, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,    2, WHITE, WHITE_FRAME_END},
        '{ROW_WIDTH,  16'd3, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_HEIGHT, 16'd3, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd0,   8'd128, -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd0,   8'd255, 8'd1,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd255, 8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd0,   8'd0,   8'd255, -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd128, 8'd127, 8'd254, -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd1,   8'd2,   8'd3,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd0,   8'd255, 8'd255, -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd254, 8'd1,   8'd128, -1, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_WIDTH,  16'd1, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_HEIGHT, 16'd3, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd10,  8'd255, 8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd11,  8'd0,   8'd255, -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd255, 8'd1,   8'd2,   -1, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_WIDTH,  16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_HEIGHT, 16'd0, 8'd0,   8'd0,   8'd0,   -1, NO_OUT, NO_OUT},
        '{ROW_PIXEL,  16'd0, 8'd18,  8'd200, 8'd7,    0, NO_OUT, NO_OUT},
        '{ROW_FLUSH,  16'd0, 8'd0,   8'd0,   8'd0,    1, LONE_PIXEL, NO_OUT}
    };

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   op          = OP_PIXEL;
    logic [CHAN_W-1:0]      pixel_red   = '0;
    logic [CHAN_W-1:0]      pixel_green = '0;
    logic [CHAN_W-1:0]      pixel_blue  = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [CHAN_W-1:0]      blur_red;
    logic [CHAN_W-1:0]      blur_green;
    logic [CHAN_W-1:0]      blur_blue;
    logic                   row_end;
    logic                   frame_end;

    // Model of the block: line stores, window, position and registers.
    logic [PIX_W-1:0]    line_older [MAX_WIDTH];
    logic [PIX_W-1:0]    line_newer [MAX_WIDTH];
    logic [PIX_W-1:0]    window_px [3][3];
    int unsigned         col_pos    = 0;
    int unsigned         row_pos    = 0;
    bit                  flush_due  = 1'b0;
    logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

    out_item_t blur_due [$];
    out_item_t new_blur [$];
    out_item_t blur_seen;

    int send_gap_pct   = 13;
    int recv_gap_pct   = 46;
    int hold_left      = 0;
    int cycles         = 0;
    int errors         = 0;
    int items_used     = 0;
    int items_ignored  = 0;
    int blurs_checked  = 0;
    int frames_run     = 0;
    int held_in_cycles = 0;

    box_blur_3x3_rgb u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .blur_red    (blur_red),
        .blur_green  (blur_green),
        .blur_blue   (blur_blue),
        .row_end     (row_end),
        .frame_end   (frame_end)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic out_item_t window_mean(int unsigned k, int unsigned orow,
                                              int unsigned ocol, int unsigned w,
                                              int unsigned h);
        int unsigned acc [3];
        int unsigned cnt;
        int unsigned lo;
        int unsigned hi;
        out_item_t   res;
        for (int ch = 0; ch < 3; ch++)
            acc[ch] = 0;
        cnt = 0;
        lo = (ocol >= 1) ? k - 1 : k;
        hi = (k < 2 && ocol + 1 <= w - 1) ? k + 1 : k;
        for (int i = 0; i < 3; i++)
        begin
            if (!((i == 0 && orow < 1) || (i == 2 && orow + 1 > h - 1)))
            begin
                for (int j = lo; j <= hi; j++)
                begin
                    for (int ch = 0; ch < 3; ch++)
                        acc[ch] += window_px[i][j][8*ch +: 8];
                    cnt++;
                end
            end
        end
        res.red       = 8'((acc[0] + cnt / 2) / cnt);
        res.green     = 8'((acc[1] + cnt / 2) / cnt);
        res.blue      = 8'((acc[2] + cnt / 2) / cnt);
        res.row_end   = (ocol == w - 1);
        res.frame_end = (ocol == w - 1) && (orow == h - 1);
        return res;
    endfunction

    // Advances the model by one accepted item; returns -1 if it is ignored.
    function automatic int blur_step(logic o, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      rw;
        logic [PIX_W-1:0] bottom;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        w = active_width();
        h = active_height();
        c = col_pos;
        rw = row_pos;
        new_blur.delete();
        if (o != flush_due)
            return -1;
        if (c >= w)
            c = w - 1;
        bottom = (o == OP_PIXEL) ? {b, g, r} : '0;
        top = line_older[c];
        mid = line_newer[c];
        if (o == OP_PIXEL)
        begin
            line_older[c] = mid;
            line_newer[c] = bottom;
        end
        for (int i = 0; i < 3; i++)
        begin
            window_px[i][0] = window_px[i][1];
            window_px[i][1] = window_px[i][2];
        end
        window_px[0][2] = top;
        window_px[1][2] = mid;
        window_px[2][2] = bottom;
        if (rw >= 1)
        begin
            if (c >= 1)
                new_blur.push_back(window_mean(1, rw - 1, c - 1, w, h));
            if (c == w - 1)
                new_blur.push_back(window_mean(2, rw - 1, c, w, h));
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            if (o == OP_FLUSH)
            begin
                rw = 0;
                flush_due = 1'b0;
            end
            else
            begin
                rw++;
                if (rw >= h)
                    flush_due = 1'b1;
            end
        end
        col_pos = c;
        row_pos = rw & 32'h1FFFF;
        return new_blur.size();
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_item(logic o, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             bit keep);
        int n;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        pixel_red   <= r;
        pixel_green <= g;
        pixel_blue  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = blur_step(o, r, g, b);
        if (n < 0)
            items_ignored++;
        else
            items_used++;
        if (keep)
        begin
            foreach (new_blur[i])
                blur_due.push_back(new_blur[i]);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (blur_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[WIDTH_W-1:0];
        else
            height_reg = value[HEIGHT_W-1:0];
        col_pos = 0;
        row_pos = 0;
        flush_due = 1'b0;
    endtask

    task automatic run_frame(logic [15:0] w_val, logic [15:0] h_val, bit write_cfg,
                             int unsigned stop_after, int unsigned pause_at,
                             int unsigned hold);
        int unsigned ew;
        int unsigned eh;
        int unsigned sent;
        bit          in_flush_row;
        if (write_cfg)
        begin
            wait_drained();
            write_reg(REG_IMAGE_WIDTH, w_val);
            write_reg(REG_IMAGE_HEIGHT, h_val);
        end
        hold_left = hold;
        ew = active_width();
        eh = active_height();
        sent = 0;
        frames_run++;
        for (int i = 0; i < ew * eh + ew; i++)
        begin
            in_flush_row = (i >= ew * eh);
            if ($urandom_range(29) == 0)
                send_item(in_flush_row ? OP_PIXEL : OP_FLUSH,
                          rand_chan(), rand_chan(), rand_chan(), 1'b1);
            send_item(in_flush_row ? OP_FLUSH : OP_PIXEL,
                      rand_chan(), rand_chan(), rand_chan(), 1'b1);
            sent++;
            if (sent == stop_after)
                break;
            if (sent == pause_at)
                wait_drained();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (blur_due.size() == 0)
            begin
                $error("Output item with nothing expected: rgb %0d %0d %0d",
                       blur_red, blur_green, blur_blue);
                errors++;
            end
            else
            begin
                blur_seen = blur_due.pop_front();
                check_field("blur_red", blur_seen.red, blur_red);
                check_field("blur_green", blur_seen.green, blur_green);
                check_field("blur_blue", blur_seen.blue, blur_blue);
                check_field("row_end", 8'(blur_seen.row_end), 8'(row_end));
                check_field("frame_end", 8'(blur_seen.frame_end), 8'(frame_end));
            end
            blurs_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (in_valid && in_stall)
            held_in_cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int  random_base;
        int  done;
        bit  last_cut;
        bit  hold_done;
        bit  cut;
        bit  reconfig;
        int  w_pick;
        int  h_pick;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                window_px[i][j] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            case (PLAN[i].kind)
                ROW_WIDTH:
                begin
                    wait_drained();
                    write_reg(REG_IMAGE_WIDTH, PLAN[i].value);
                end
                ROW_HEIGHT:
                begin
                    wait_drained();
                    write_reg(REG_IMAGE_HEIGHT, PLAN[i].value);
                end
                default:
                begin
                    send_item((PLAN[i].kind == ROW_FLUSH) ? OP_FLUSH : OP_PIXEL,
                              PLAN[i].red, PLAN[i].green, PLAN[i].blue,
                              PLAN[i].nres < 0);
                    if (PLAN[i].nres > 0)
                        blur_due.push_back(PLAN[i].first);
                    if (PLAN[i].nres > 1)
                        blur_due.push_back(PLAN[i].second);
                end
            endcase
        end

        // Widest and tallest frames with all register bits set, both cut short.
        run_frame(16'hFFFF, 16'd2, 1'b1, 200, 0, 0);
        run_frame(16'd3, 16'hFFFF, 1'b1, 40, 0, 0);

        random_base = items_used;
        last_cut = 1'b1;
        hold_done = 1'b0;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (done < RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 13;
                recv_gap_pct = 46;
            end
            else if (done < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 46;
                recv_gap_pct = 13;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            if (send_gap_pct == 0 && !hold_done)
            begin
                run_frame(16'd32, 16'd8, 1'b1, 0, 150, HOLD_CYCLES);
                hold_done = 1'b1;
                last_cut = 1'b0;
            end
            else
            begin
                case ($urandom_range(9))
                    0: w_pick = $urandom_range(0, 1);
                    1: w_pick = $urandom_range(13, 64);
                    default: w_pick = $urandom_range(2, 12);
                endcase
                h_pick = $urandom_range(0, 6);
                cut = ($urandom_range(7) == 0);
                reconfig = last_cut || ($urandom_range(2) != 0);
                run_frame(16'(w_pick), 16'(h_pick), reconfig,
                          cut ? $urandom_range(1, 30) : 0, 0, 0);
                last_cut = cut;
            end
            done = items_used - random_base;
        end

        wait_drained();
        $display("Ran %0d frames: %0d items taken, %0d ignored, %0d blurred pixels checked.",
                 frames_run, items_used, items_ignored, blurs_checked);
        $display("Input held off for %0d cycles; sizes from 0 up to 4095 x 65535 written.",
                 held_in_cycles);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
